// ----- hw/rtl/itzd_pkg.sv -----
// Package for the integer to zoned decimal converter.
// Holds widths, register indexes, reset values and character codes; no dependencies.
`default_nettype none

package itzd_pkg;

	localparam int MAX_DIGITS_DEF = 31;
	localparam int VALUE_W        = 32;
	localparam int BYTE_W         = 8;
	localparam int CFG_W          = 5;
	localparam int CFG_IDX_W      = 1;
	localparam int DEC_DIGITS     = 10;
	localparam int DIGIT_W        = 4;
	localparam int DIGIT_IDX_W    = 4;

	localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRACTION_COUNT = 1'b1;

	localparam logic [CFG_W-1:0] DIGIT_COUNT_RST    = 5'd9;
	localparam logic [CFG_W-1:0] FRACTION_COUNT_RST = 5'd0;

	localparam logic [3:0] ZONE_PLAIN = 4'h3;
	localparam logic [3:0] ZONE_NEG   = 4'hD;

endpackage

`default_nettype wire

// ----- hw/rtl/integer_to_zoned_decimal.sv -----
// Integer to zoned decimal converter, top level.
// Uses itzd_pkg; double-dabble conversion then byte-per-cycle emission while the output is not stalled.
//
//  channel  | signals                              | dir
//  ---------+--------------------------------------+-----
//  input    | in_valid, in_stall, value            | in
//  output   | out_valid, out_stall, zoned_byte,    | out
//           | last_byte                            |
//  config   | cfg_we, cfg_index, cfg_data          | in
//
// One item: a transfer, then conversion at one bit per cycle through the per-digit
// add-3/shift cells, then n field bytes (n = digit count), one per cycle unless stalled.
// Reset clears the sequencer and the output valid and sets the config registers to their defaults.
// A stalled output holds its byte and pauses emission; input stays stalled
// until the last byte of the field is loaded into the output register.
`default_nettype none

module integer_to_zoned_decimal #(
	parameter int MAX_DIGITS = itzd_pkg::MAX_DIGITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [itzd_pkg::VALUE_W-1:0] value,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic        [itzd_pkg::BYTE_W-1:0]     zoned_byte,
	output logic                                   last_byte,
	input  wire logic                              cfg_we,
	input  wire logic   [itzd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic   [itzd_pkg::CFG_W-1:0]      cfg_data
);
	import itzd_pkg::*;

	localparam int PW = $clog2(MAX_DIGITS + 1);
	localparam int NW = (PW > CFG_W) ? PW : CFG_W;
	localparam int BW = $clog2(VALUE_W);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t               state_q;
	logic [CFG_W-1:0]     digit_count_q;
	logic [CFG_W-1:0]     fraction_count_q;
	logic [VALUE_W-1:0]   mag_q;
	logic                 neg_q;
	logic [BW-1:0]        bit_q;
	logic [PW-1:0]        pos_q;
	logic [DIGIT_W-1:0]   dig_q [DEC_DIGITS];
	logic [DIGIT_W-1:0]   adj   [DEC_DIGITS];
	logic                 out_valid_q;
	logic [BYTE_W-1:0]    zoned_byte_q;
	logic                 last_byte_q;

	logic [NW-1:0]        n_eff;
	logic [NW-1:0]        f_eff;
	logic [NW-1:0]        ip;
	logic [NW-1:0]        r;
	logic [NW-1:0]        pos_ext;
	logic [DIGIT_W-1:0]   emit_digit;
	logic                 emit_last;
	logic                 emit_go;
	logic                 in_xfer;

	assign in_xfer = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		if (NW'(digit_count_q) > NW'(MAX_DIGITS)) begin
			n_eff = NW'(MAX_DIGITS);
		end else begin
			n_eff = NW'(digit_count_q);
		end
		if (NW'(fraction_count_q) > n_eff) begin
			f_eff = n_eff;
		end else begin
			f_eff = NW'(fraction_count_q);
		end
		ip      = n_eff - f_eff;
		pos_ext = NW'(pos_q);
		r       = ip - NW'(1) - pos_ext;
		emit_digit = '0;
		if (pos_ext < ip && r < NW'(DEC_DIGITS)) begin
			emit_digit = dig_q[r[DIGIT_IDX_W-1:0]];
		end
		emit_last = (pos_ext == n_eff - NW'(1));
		emit_go   = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	end

	always_comb begin
		for (int k = 0; k < DEC_DIGITS; k++) begin
			adj[k] = (dig_q[k] >= DIGIT_W'(5)) ? dig_q[k] + DIGIT_W'(3) : dig_q[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q    <= DIGIT_COUNT_RST;
			fraction_count_q <= FRACTION_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIGIT_COUNT:    digit_count_q    <= cfg_data;
				REG_FRACTION_COUNT: fraction_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			bit_q       <= '0;
			pos_q       <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_CONV;
						bit_q   <= '0;
					end
				end
				ST_CONV: begin
					bit_q <= bit_q + BW'(1);
					if (bit_q == BW'(VALUE_W - 1)) begin
						pos_q   <= '0;
						state_q <= (n_eff == '0) ? ST_IDLE : ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						out_valid_q <= 1'b1;
						pos_q       <= pos_q + PW'(1);
						if (emit_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: magnitude, sign, BCD digits, output byte
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			neg_q <= value[VALUE_W-1];
			mag_q <= value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(value)) : VALUE_W'(value);
			for (int k = 0; k < DEC_DIGITS; k++) begin
				dig_q[k] <= '0;
			end
		end else if (state_q == ST_CONV) begin
			mag_q    <= {mag_q[VALUE_W-2:0], 1'b0};
			dig_q[0] <= {adj[0][DIGIT_W-2:0], mag_q[VALUE_W-1]};
			for (int k = 1; k < DEC_DIGITS; k++) begin
				dig_q[k] <= {adj[k][DIGIT_W-2:0], adj[k-1][DIGIT_W-1]};
			end
		end
		if (emit_go) begin
			zoned_byte_q <= {(emit_last && neg_q) ? ZONE_NEG : ZONE_PLAIN, emit_digit};
			last_byte_q  <= emit_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign zoned_byte = zoned_byte_q;
	assign last_byte  = last_byte_q;

endmodule

`default_nettype wire

// ----- hw/rtl/itzd_checker.sv -----
// Port-level checker for integer_to_zoned_decimal, with its bind.
// Uses itzd_pkg for widths and zone codes.
`default_nettype none

module itzd_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_stall,
	input wire logic                              out_valid,
	input wire logic                              out_stall,
	input wire logic [itzd_pkg::BYTE_W-1:0]       zoned_byte,
	input wire logic                              last_byte
);
	import itzd_pkg::*;

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a conversion is starting");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(zoned_byte) && $stable(last_byte))
		else $error("stalled output changed");

	a_zone_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (zoned_byte[7:4] == ZONE_PLAIN || zoned_byte[7:4] == ZONE_NEG))
		else $error("bad zone nibble");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> zoned_byte[3:0] <= 4'd9)
		else $error("digit out of range");

	a_sign_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zoned_byte[7:4] == ZONE_NEG |-> last_byte)
		else $error("negative zone on a non-final byte");

endmodule

bind integer_to_zoned_decimal itzd_checker u_itzd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.zoned_byte (zoned_byte),
	.last_byte  (last_byte)
);

`default_nettype wire

// ----- tb/tb_integer_to_zoned_decimal.sv -----
// Self-checking testbench for integer_to_zoned_decimal: directed and random integers
// across several field layouts, expected bytes predicted per transfer and compared in order.
// Depends on itzd_pkg and the integer_to_zoned_decimal top level.

module tb_integer_to_zoned_decimal;
	timeunit 1ns;
	timeprecision 1ps;

	import itzd_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int unsigned SETTLE_CYCLES = 80;
	localparam int unsigned LONG_HOLD = 400;
	localparam int unsigned DEC_BASE = 10;
	localparam int unsigned RAND_PHASES = 8;
	localparam int unsigned RAND_ITEMS = 27;
	localparam logic [BYTE_W-1:0] ASCII_ZERO = {ZONE_PLAIN, 4'h0};

	typedef struct packed {
		logic [BYTE_W-1:0] zbyte;
		logic              last;
	} field_byte_t;

	typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [VALUE_W-1:0] value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [BYTE_W-1:0] zoned_byte;
	logic last_byte;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_DIGIT_COUNT;
	logic [CFG_W-1:0] cfg_data = '0;

	logic [VALUE_W-1:0] value_q[$];
	field_byte_t field_q[$];
	field_byte_t want;
	logic [CFG_W-1:0] cfg_digits = DIGIT_COUNT_RST;
	logic [CFG_W-1:0] cfg_fraction = FRACTION_COUNT_RST;

	int unsigned gap_left = 0;
	int unsigned burst_left = 1;
	logic steady = 1'b0;
	logic long_hold_req = 1'b0;
	int unsigned hold_left = 0;
	int unsigned mode_left = 0;
	rx_mode_t rx_mode = RX_FREE;
	int unsigned cycles = 0;
	int unsigned errors = 0;

	integer_to_zoned_decimal u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.zoned_byte(zoned_byte),
		.last_byte (last_byte),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// Expected field bytes for one integer under the current layout.
	function automatic void predict_field(input logic [VALUE_W-1:0] raw);
		logic [VALUE_W-1:0] mag;
		logic [DIGIT_W-1:0] digs [DEC_DIGITS];
		int unsigned n, f, ip, r;
		logic [BYTE_W-1:0] b;
		field_byte_t fb;
		bit neg;
		neg = raw[VALUE_W-1];
		mag = neg ? (~raw + 1'b1) : raw;
		for (int k = 0; k < DEC_DIGITS; k++) begin
			digs[k] = DIGIT_W'(mag % DEC_BASE);
			mag = mag / DEC_BASE;
		end
		n = cfg_digits;
		if (n > MAX_DIGITS_DEF)
			n = MAX_DIGITS_DEF;
		if (n == 0)
			return;
		f = cfg_fraction;
		if (f > n)
			f = n;
		ip = n - f;
		for (int unsigned p = 0; p < n; p++) begin
			b = ASCII_ZERO;
			if (p < ip) begin
				r = ip - 1 - p;
				if (r < DEC_DIGITS)
					b = ASCII_ZERO + BYTE_W'(digs[r]);
			end
			if (p == n - 1 && neg)
				b = {ZONE_NEG, b[3:0]};
			fb.zbyte = b;
			fb.last = (p == n - 1);
			field_q.push_back(fb);
		end
	endfunction

	function automatic logic [VALUE_W-1:0] rand_value();
		logic [VALUE_W-1:0] v;
		case ($urandom_range(0, 5))
			0: v = $urandom_range(0, 99);
			1: v = $urandom_range(0, 999999);
			2: begin
				case ($urandom_range(0, 5))
					0: v = 32'h7FFF_FFFF;
					1: v = 32'h8000_0000;
					2: v = '0;
					3: v = 32'd999_999_999;
					4: v = 32'd1_000_000_000;
					default: v = 32'd1_000_000_001;
				endcase
			end
			default: v = $urandom;
		endcase
		if ($urandom_range(0, 1))
			v = ~v + 1'b1;
		return v;
	endfunction

	// Sender: bursts of transfers with random gaps between them.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			value <= '0;
		end else begin
			if (in_valid && !in_stall)
				predict_field(value);
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (value_q.size() > 0) begin
					in_valid <= 1'b1;
					value <= value_q.pop_front();
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 12);
						if (steady)
							gap_left = 0;
						else if ($urandom_range(0, 3) == 0)
							gap_left = $urandom_range(5, 30);
						else
							gap_left = $urandom_range(0, 4);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall pattern changes mode every so often; long hold on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (long_hold_req)
				hold_left = LONG_HOLD;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 120);
				end else begin
					mode_left--;
				end
				case (rx_mode)
					RX_FREE:  out_stall <= 1'b0;
					RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					RX_HEAVY: out_stall <= ($urandom_range(0, 1) == 1);
					default:  out_stall <= ((cycles % 5) < 2);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (field_q.size() == 0) begin
				errors++;
				$display("%0t: byte with nothing expected: expected none, actual %h last %b",
					$time, zoned_byte, last_byte);
			end else begin
				want = field_q.pop_front();
				if (zoned_byte !== want.zbyte) begin
					errors++;
					$display("%0t: zoned_byte mismatch: expected %h, actual %h",
						$time, want.zbyte, zoned_byte);
				end
				if (last_byte !== want.last) begin
					errors++;
					$display("%0t: last_byte mismatch: expected %b, actual %b",
						$time, want.last, last_byte);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic wait_idle();
		@(negedge clk);
		while (value_q.size() != 0 || in_valid || field_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DIGIT_COUNT)
			cfg_digits = data;
		else
			cfg_fraction = data;
		@(negedge clk);
	endtask

	initial begin
		int unsigned dc;
		int unsigned fc;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset layout: nine digits, no fraction; truncation and most negative value
		value_q = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'd123456789, -32'sd123456789, 32'd999999999, 32'd1000000000,
			-32'sd1000000000, 32'h5555_5555, 32'hAAAA_AAAA};
		write_reg(REG_DIGIT_COUNT, 5'd31);
		value_q = '{32'h7FFF_FFFF, 32'h8000_0000};
		write_reg(REG_DIGIT_COUNT, 5'd1);
		value_q = '{-32'sd7, 32'd123};
		// empty field
		write_reg(REG_DIGIT_COUNT, 5'd0);
		value_q = '{32'd5, -32'sd5};
		// negative value with fraction digits
		write_reg(REG_DIGIT_COUNT, 5'd12);
		write_reg(REG_FRACTION_COUNT, 5'd3);
		value_q = '{-32'sd42, 32'd42};
		// fraction wider than the field
		write_reg(REG_DIGIT_COUNT, 5'd5);
		write_reg(REG_FRACTION_COUNT, 5'd31);
		value_q = '{-32'sd3, 32'd77};
		write_reg(REG_DIGIT_COUNT, 5'd31);
		value_q = '{-32'sd1, 32'd9};

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case ($urandom_range(0, 3))
				0: dc = 31;
				1: dc = $urandom_range(1, 10);
				default: dc = $urandom_range(1, 31);
			endcase
			case ($urandom_range(0, 3))
				0: fc = 0;
				1: fc = 31;
				2: fc = $urandom_range(0, dc);
				default: fc = $urandom_range(0, 31);
			endcase
			write_reg(REG_DIGIT_COUNT, CFG_W'(dc));
			write_reg(REG_FRACTION_COUNT, CFG_W'(fc));
			@(posedge clk);
			steady <= (ph == 5);
			@(negedge clk);
			if (ph == 3) begin
				// sender drains everything before offering the second half
				for (int i = 0; i < RAND_ITEMS / 2; i++)
					value_q.push_back(rand_value());
				wait_idle();
				for (int i = RAND_ITEMS / 2; i < RAND_ITEMS; i++)
					value_q.push_back(rand_value());
			end else begin
				for (int i = 0; i < RAND_ITEMS; i++)
					value_q.push_back(rand_value());
			end
			if (ph == 1) begin
				@(posedge clk);
				long_hold_req <= 1'b1;
				@(posedge clk);
				long_hold_req <= 1'b0;
				@(negedge clk);
			end
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
